// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the voxel map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define VHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define VHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/vhm_pkg.sv =====
// Package with types, constants and helpers of the voxel map.
`timescale 1ns / 1ps
`default_nettype none
package vhm_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int MAX_POINTS  = 20;
  localparam int KEY_BITS    = 24;

  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int FILL_W   = $clog2(MAX_POINTS + 1);
  localparam int PS_DEPTH = TABLE_SLOTS * MAX_POINTS;
  localparam int PS_AW    = $clog2(PS_DEPTH);

  localparam int COORD_W    = 32;
  localparam int EDGE_W     = 20;
  localparam int CAP_W      = 5;
  localparam int RADIUS_W   = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int SEL_SLOT_W = 10;
  localparam int SEL_PT_W   = 5;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_EDGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RADIUS = 2'd2;

  localparam logic [EDGE_W-1:0]   EDGE_RST   = 20'd65536;
  localparam logic [CAP_W-1:0]    CAP_RST    = 5'd20;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd6553600;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PRUNE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADD_OLD    = 3'd0,
    ST_ADD_NEW    = 3'd1,
    ST_VOX_FULL   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_PRUNED     = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_READ_EMPTY = 3'd6
  } status_e;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef struct packed {
    op_e                   op;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    key_t                  kx;
    key_t                  ky;
    key_t                  kz;
    logic [SEL_SLOT_W-1:0] slot_sel;
    logic [SEL_PT_W-1:0]   point_sel;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    coord_t               x;
    coord_t               y;
    coord_t               z;
    key_t                 kx;
    key_t                 ky;
    key_t                 kz;
    logic [COUNT_W-1:0]   removed;
  } result_t;

  typedef struct packed {
    logic              valid;
    key_t              kx;
    key_t              ky;
    key_t              kz;
    logic [FILL_W-1:0] fill;
  } slot_ent_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [PS_AW-1:0] ps_index(input logic [SLOT_W-1:0] slot,
                                                input logic [PS_AW-1:0]  pt);
    return PS_AW'(slot) * PS_AW'(MAX_POINTS) + pt;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vhm_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface vhm_in_if import vhm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  coord_t                pos_x;
  coord_t                pos_y;
  coord_t                pos_z;
  logic [SEL_SLOT_W-1:0] slot_sel;
  logic [SEL_PT_W-1:0]   point_sel;

  modport source (output valid, op, pos_x, pos_y, pos_z, slot_sel, point_sel,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, pos_z, slot_sel, point_sel,
                output ready);
endinterface

interface vhm_out_if import vhm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  coord_t              out_x;
  coord_t              out_y;
  coord_t              out_z;
  key_t                cell_x;
  key_t                cell_y;
  key_t                cell_z;
  logic [COUNT_W-1:0]  removed_count;

  modport source (output valid, status, out_x, out_y, out_z, cell_x, cell_y, cell_z,
                  removed_count, input ready);
  modport sink (input valid, status, out_x, out_y, out_z, cell_x, cell_y, cell_z,
                removed_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/vhm_front.sv =====
// Command intake with the bit-serial voxel key divider.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vhm_front import vhm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  vhm_in_if.sink           in_i,
  input  wire logic [EDGE_W-1:0] voxel_edge_i,
  input  wire back_stat_t  back_stat_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output cmd_t             push_cmd_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam int CNT_W = $clog2(COORD_W);
  localparam int REM_W = EDGE_W + 1;

  localparam logic [COORD_W-1:0] KEY_MAX = COORD_W'((64'd1 << (KEY_BITS - 1)) - 64'd1);
  localparam logic [COORD_W-1:0] KEY_MIN_MAG = COORD_W'(64'd1 << (KEY_BITS - 1));

  logic [1:0]         state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [COORD_W-1:0] quo_q [3];
  logic [COORD_W-1:0] quo_d [3];
  logic [REM_W-1:0]   rem_q [3];
  logic [REM_W-1:0]   rem_d [3];
  logic [2:0]         neg_q, neg_d;
  logic [EDGE_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  coord_t             in_pos [3];
  logic               accept;

  function automatic key_t sat_key(input logic [COORD_W-1:0] mag, input logic neg);
    key_t k;
    if (!neg) begin
      k = (mag > KEY_MAX) ? key_t'(KEY_MAX[KEY_BITS-1:0]) : key_t'(mag[KEY_BITS-1:0]);
    end else begin
      k = (mag > KEY_MIN_MAG) ? key_t'(KEY_MIN_MAG[KEY_BITS-1:0])
                              : -key_t'(mag[KEY_BITS-1:0]);
    end
    return k;
  endfunction

  assign in_pos[0] = in_i.pos_x;
  assign in_pos[1] = in_i.pos_y;
  assign in_pos[2] = in_i.pos_z;

  assign in_i.ready   = (state_q == F_IDLE) && !back_stat_i.clearing;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = (state_q == F_PUSH);

  always_comb begin
    logic [REM_W-1:0] shifted;
    logic [REM_W:0]   trial;
    logic             qbit;
    state_d = state_q;
    cmd_d   = cmd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    shifted = '0;
    trial   = '0;
    qbit    = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          cmd_d.op        = op_e'(in_i.op);
          cmd_d.x         = in_i.pos_x;
          cmd_d.y         = in_i.pos_y;
          cmd_d.z         = in_i.pos_z;
          cmd_d.kx        = '0;
          cmd_d.ky        = '0;
          cmd_d.kz        = '0;
          cmd_d.slot_sel  = in_i.slot_sel;
          cmd_d.point_sel = in_i.point_sel;
          div_d = (voxel_edge_i == '0) ? EDGE_W'(1) : voxel_edge_i;
          cnt_d = '0;
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = in_pos[i][COORD_W-1];
            quo_d[i] = neg_d[i] ? COORD_W'(-in_pos[i]) : COORD_W'(in_pos[i]);
            rem_d[i] = '0;
          end
          state_d = (op_e'(in_i.op) == OP_ADD) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        for (int i = 0; i < 3; i++) begin
          shifted = {rem_q[i][REM_W-2:0], quo_q[i][COORD_W-1]};
          trial   = {1'b0, shifted} - {2'b00, div_q};
          qbit    = !trial[REM_W];
          rem_d[i] = qbit ? trial[REM_W-1:0] : shifted;
          quo_d[i] = {quo_q[i][COORD_W-2:0], qbit};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(COORD_W - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_comb begin
    push_cmd_o = cmd_q;
    if (cmd_q.op == OP_ADD) begin
      push_cmd_o.kx = sat_key(quo_q[0], neg_q[0]);
      push_cmd_o.ky = sat_key(quo_q[1], neg_q[1]);
      push_cmd_o.kz = sat_key(quo_q[2], neg_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    div_q <= div_d;
  end

  `VHM_ASSERT(a_div_only_add, (state_q == F_DIV) |-> (cmd_q.op == OP_ADD), "divider runs for non-add")
  `VHM_ASSERT(a_div_to_push, ((state_q == F_DIV) && (cnt_q == CNT_W'(COORD_W - 1))) |=> (state_q == F_PUSH), "divider overran")

endmodule
`default_nettype wire

// ===== rtl/vhm_queue.sv =====
// Two-entry command queue between intake and execution.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vhm_queue import vhm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `VHM_ASSERT(a_count_bound, int'(count_q) <= QDEPTH, "queue count beyond depth")

endmodule
`default_nettype wire

// ===== rtl/vhm_back.sv =====
// Execution engine: slot table, point store, add scan, prune walk and read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vhm_back import vhm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  input  wire cmd_t                pop_cmd_i,
  input  wire logic [CAP_W-1:0]    points_per_voxel_i,
  input  wire logic [RADIUS_W-1:0] keep_radius_i,
  output back_stat_t               back_stat_o,
  vhm_out_if.source                out_o
);

  localparam logic [3:0] B_CLR    = 4'd0;
  localparam logic [3:0] B_IDLE   = 4'd1;
  localparam logic [3:0] B_ASCAN  = 4'd2;
  localparam logic [3:0] B_ADRAIN = 4'd3;
  localparam logic [3:0] B_AACT   = 4'd4;
  localparam logic [3:0] B_PRD    = 4'd5;
  localparam logic [3:0] B_PABS   = 4'd6;
  localparam logic [3:0] B_PSQ    = 4'd7;
  localparam logic [3:0] B_PCMP   = 4'd8;
  localparam logic [3:0] B_RRD    = 4'd9;
  localparam logic [3:0] B_RWAIT  = 4'd10;
  localparam logic [3:0] B_DONE   = 4'd11;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int R2_W   = 2 * RADIUS_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  logic [3:0]          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [SLOT_W-1:0]   scan_q, scan_d;
  logic                rd_v_q, rd_v_d;
  logic [SLOT_W-1:0]   rd_idx_q, rd_idx_d;
  logic                found_v_q, found_v_d;
  logic [SLOT_W-1:0]   found_q, found_d;
  logic [FILL_W-1:0]   found_fill_q, found_fill_d;
  logic                free_v_q, free_v_d;
  logic [SLOT_W-1:0]   free_q, free_d;
  logic [COUNT_W-1:0]  removed_q, removed_d, removed_n;
  logic [R2_W-1:0]     r2_q, r2_d;
  logic [DIFF_W-1:0]   absd_q [3];
  logic [DIFF_W-1:0]   absd_d [3];
  logic [DIFF_W-1:0]   absd_c [3];
  logic [SQ_W-1:0]     sq_q [3];
  logic [SQ_W-1:0]     sq_d [3];
  result_t             pend_q, pend_d;
  result_t             res_q, res_d;
  logic                res_valid_q, res_valid_d;
  logic                res_load;

  slot_ent_t           slot_mem [TABLE_SLOTS];
  slot_ent_t           sm_rdata_q;
  logic                sm_we;
  logic [SLOT_W-1:0]   sm_waddr, sm_raddr;
  slot_ent_t           sm_wdata;

  point_t              ps_mem [PS_DEPTH];
  point_t              ps_rdata_q;
  logic                ps_we;
  logic [PS_AW-1:0]    ps_waddr, ps_raddr, rd_addr;
  point_t              ps_wdata, cmd_pt;

  coord_t              pt_c [3];
  coord_t              pos_c [3];
  logic                key_match, too_far, rd_ok;
  logic [FILL_W-1:0]   cap;
  logic [SUM_W-1:0]    dist2;

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      slot_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_q <= slot_mem[sm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) begin
      ps_mem[ps_waddr] <= ps_wdata;
    end
    ps_rdata_q <= ps_mem[ps_raddr];
  end

  assign pt_c[0]  = ps_rdata_q.x;
  assign pt_c[1]  = ps_rdata_q.y;
  assign pt_c[2]  = ps_rdata_q.z;
  assign pos_c[0] = cmd_q.x;
  assign pos_c[1] = cmd_q.y;
  assign pos_c[2] = cmd_q.z;
  assign cmd_pt   = '{x: cmd_q.x, y: cmd_q.y, z: cmd_q.z};

  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      diff      = {pt_c[i][COORD_W-1], pt_c[i]} - {pos_c[i][COORD_W-1], pos_c[i]};
      absd_c[i] = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end
  end

  assign key_match = (sm_rdata_q.kx == cmd_q.kx) && (sm_rdata_q.ky == cmd_q.ky) &&
                     (sm_rdata_q.kz == cmd_q.kz);
  assign cap = (int'(points_per_voxel_i) > MAX_POINTS) ? FILL_W'(MAX_POINTS)
                                                      : FILL_W'(points_per_voxel_i);
  assign dist2   = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  assign too_far = dist2 > SUM_W'(r2_q);
  assign rd_ok   = sm_rdata_q.valid && (int'(cmd_q.slot_sel) < TABLE_SLOTS) &&
                   (int'(cmd_q.point_sel) < int'(sm_rdata_q.fill)) &&
                   (int'(cmd_q.point_sel) < MAX_POINTS);
  assign rd_addr = ps_index(SLOT_W'(cmd_q.slot_sel),
                            (int'(cmd_q.point_sel) < MAX_POINTS) ? PS_AW'(cmd_q.point_sel)
                                                                : '0);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    scan_d       = scan_q;
    rd_v_d       = rd_v_q;
    rd_idx_d     = rd_idx_q;
    found_v_d    = found_v_q;
    found_d      = found_q;
    found_fill_d = found_fill_q;
    free_v_d     = free_v_q;
    free_d       = free_q;
    removed_d    = removed_q;
    removed_n    = removed_q;
    r2_d         = r2_q;
    absd_d       = absd_q;
    sq_d         = sq_q;
    pend_d       = pend_q;
    sm_we        = 1'b0;
    sm_waddr     = scan_q;
    sm_wdata     = '0;
    sm_raddr     = scan_q;
    ps_we        = 1'b0;
    ps_waddr     = '0;
    ps_wdata     = cmd_pt;
    ps_raddr     = ps_index(scan_q, '0);
    pop_ready_o  = 1'b0;
    res_load     = 1'b0;

    if (rd_v_q && ((state_q == B_ASCAN) || (state_q == B_ADRAIN))) begin
      if (sm_rdata_q.valid) begin
        if (!found_v_q && key_match) begin
          found_v_d    = 1'b1;
          found_d      = rd_idx_q;
          found_fill_d = sm_rdata_q.fill;
        end
      end else if (!free_v_q) begin
        free_v_d = 1'b1;
        free_d   = rd_idx_q;
      end
    end

    unique case (state_q)
      B_CLR: begin
        sm_we    = 1'b1;
        sm_waddr = scan_q;
        scan_d   = scan_q + SLOT_W'(1);
        if (scan_q == SLOT_LAST) begin
          scan_d  = '0;
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          cmd_d     = pop_cmd_i;
          scan_d    = '0;
          removed_d = '0;
          found_v_d = 1'b0;
          free_v_d  = 1'b0;
          rd_v_d    = 1'b0;
          r2_d      = R2_W'(keep_radius_i) * R2_W'(keep_radius_i);
          pend_d    = '0;
          unique case (pop_cmd_i.op)
            OP_ADD:   state_d = B_ASCAN;
            OP_PRUNE: state_d = B_PRD;
            OP_READ:  state_d = B_RRD;
            OP_NONE: begin
              pend_d.status = ST_READ_EMPTY;
              state_d       = B_DONE;
            end
            default: begin
              pend_d.status = ST_READ_EMPTY;
              state_d       = B_DONE;
            end
          endcase
        end
      end
      B_ASCAN: begin
        sm_raddr = scan_q;
        rd_v_d   = 1'b1;
        rd_idx_d = scan_q;
        if (scan_q == SLOT_LAST) begin
          state_d = B_ADRAIN;
        end else begin
          scan_d = scan_q + SLOT_W'(1);
        end
      end
      B_ADRAIN: begin
        rd_v_d  = 1'b0;
        state_d = B_AACT;
      end
      B_AACT: begin
        pend_d    = '0;
        pend_d.kx = cmd_q.kx;
        pend_d.ky = cmd_q.ky;
        pend_d.kz = cmd_q.kz;
        if (found_v_q) begin
          if (found_fill_q < cap) begin
            ps_we    = 1'b1;
            ps_waddr = ps_index(found_q, PS_AW'(found_fill_q));
            sm_we    = 1'b1;
            sm_waddr = found_q;
            sm_wdata = '{valid: 1'b1, kx: cmd_q.kx, ky: cmd_q.ky, kz: cmd_q.kz,
                         fill: found_fill_q + FILL_W'(1)};
            pend_d.status = ST_ADD_OLD;
          end else begin
            pend_d.status = ST_VOX_FULL;
          end
        end else if (free_v_q) begin
          ps_we    = 1'b1;
          ps_waddr = ps_index(free_q, '0);
          sm_we    = 1'b1;
          sm_waddr = free_q;
          sm_wdata = '{valid: 1'b1, kx: cmd_q.kx, ky: cmd_q.ky, kz: cmd_q.kz,
                       fill: FILL_W'(1)};
          pend_d.status = ST_ADD_NEW;
        end else begin
          pend_d.status = ST_TABLE_FULL;
        end
        state_d = B_DONE;
      end
      B_PRD: begin
        sm_raddr = scan_q;
        ps_raddr = ps_index(scan_q, '0);
        state_d  = B_PABS;
      end
      B_PABS: begin
        if (sm_rdata_q.valid) begin
          absd_d  = absd_c;
          state_d = B_PSQ;
        end else if (scan_q == SLOT_LAST) begin
          pend_d         = '0;
          pend_d.status  = ST_PRUNED;
          pend_d.removed = removed_q;
          state_d        = B_DONE;
        end else begin
          scan_d  = scan_q + SLOT_W'(1);
          state_d = B_PRD;
        end
      end
      B_PSQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_d[i] = SQ_W'(absd_q[i]) * SQ_W'(absd_q[i]);
        end
        state_d = B_PCMP;
      end
      B_PCMP: begin
        if (too_far) begin
          sm_we     = 1'b1;
          sm_waddr  = scan_q;
          removed_n = removed_q + COUNT_W'(1);
        end
        removed_d = removed_n;
        if (scan_q == SLOT_LAST) begin
          pend_d         = '0;
          pend_d.status  = ST_PRUNED;
          pend_d.removed = removed_n;
          state_d        = B_DONE;
        end else begin
          scan_d  = scan_q + SLOT_W'(1);
          state_d = B_PRD;
        end
      end
      B_RRD: begin
        sm_raddr = SLOT_W'(cmd_q.slot_sel);
        ps_raddr = rd_addr;
        state_d  = B_RWAIT;
      end
      B_RWAIT: begin
        pend_d = '0;
        if (rd_ok) begin
          pend_d.status = ST_READ_OK;
          pend_d.x      = ps_rdata_q.x;
          pend_d.y      = ps_rdata_q.y;
          pend_d.z      = ps_rdata_q.z;
          pend_d.kx     = sm_rdata_q.kx;
          pend_d.ky     = sm_rdata_q.ky;
          pend_d.kz     = sm_rdata_q.kz;
        end else begin
          pend_d.status = ST_READ_EMPTY;
        end
        state_d = B_DONE;
      end
      B_DONE: begin
        if (!res_valid_q || out_o.ready) begin
          res_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_load) begin
      res_valid_d = 1'b1;
      res_d       = pend_q;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign back_stat_o.clearing = (state_q == B_CLR);

  assign out_o.valid         = res_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.out_x         = res_q.x;
  assign out_o.out_y         = res_q.y;
  assign out_o.out_z         = res_q.z;
  assign out_o.cell_x        = res_q.kx;
  assign out_o.cell_y        = res_q.ky;
  assign out_o.cell_z        = res_q.kz;
  assign out_o.removed_count = res_q.removed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      scan_q      <= '0;
      rd_v_q      <= 1'b0;
      found_v_q   <= 1'b0;
      free_v_q    <= 1'b0;
      removed_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      rd_v_q      <= rd_v_d;
      found_v_q   <= found_v_d;
      free_v_q    <= free_v_d;
      removed_q   <= removed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rd_idx_q     <= rd_idx_d;
    found_q      <= found_d;
    found_fill_q <= found_fill_d;
    free_q       <= free_d;
    r2_q         <= r2_d;
    absd_q       <= absd_d;
    sq_q         <= sq_d;
    pend_q       <= pend_d;
    res_q        <= res_d;
  end

  `VHM_ASSERT(a_clr_quiet, (state_q == B_CLR) |-> !res_valid_q, "result during clearing pass")
  `VHM_ASSERT(a_ps_range, ps_we |-> (int'(ps_waddr) < PS_DEPTH), "point store write out of range")
  `VHM_ASSERT(a_removed_bound, int'(removed_q) <= TABLE_SLOTS, "prune count beyond table size")

endmodule
`default_nettype wire

// ===== rtl/voxel_hash_map_insert_prune_unit.sv =====
// Voxel hash map top level: configuration registers, intake, queue and execution.
//
// Commands enter on in_i (valid/ready) and give exactly one result on out_o.
// op 0 adds a point: a bit-serial divider forms the voxel key, then every one
// of the 1024 slots is read once (one per cycle) to find the key and the lowest
// free slot. op 1 prunes: each slot is read and checked for a valid entry; an
// occupied slot's distance is then squared and compared with the keep radius.
// op 2 reads one point. Throughput is one command at a time through the
// execution engine; a two-entry queue lets the intake take and pre-divide the
// next add. After reset a clearing pass over all 1024 slots marks them free;
// in_i.ready stays low until it ends. A stalled receiver holds the result in the
// output register; the engine waits with the next result, and intake goes on
// until the queue is full. Configuration is written with cfg_we_i while idle.
`timescale 1ns / 1ps
`default_nettype none
module voxel_hash_map_insert_prune_unit import vhm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  vhm_in_if.sink                     in_i,
  vhm_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [EDGE_W-1:0]   edge_q;
  logic [CAP_W-1:0]    cap_q;
  logic [RADIUS_W-1:0] radius_q;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  cmd_t       push_cmd, pop_cmd;
  back_stat_t back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= EDGE_RST;
      cap_q    <= CAP_RST;
      radius_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOXEL_EDGE:  edge_q   <= cfg_wdata_i[EDGE_W-1:0];
        CFG_POINTS_PER:  cap_q    <= cfg_wdata_i[CAP_W-1:0];
        CFG_KEEP_RADIUS: radius_q <= cfg_wdata_i[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  vhm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .voxel_edge_i (edge_q),
    .back_stat_i  (back_stat),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  vhm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  vhm_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_ready_o        (pop_ready),
    .pop_cmd_i          (pop_cmd),
    .points_per_voxel_i (cap_q),
    .keep_radius_i      (radius_q),
    .back_stat_o        (back_stat),
    .out_o              (out_o)
  );

endmodule
`default_nettype wire

// ===== verif/voxel_hash_map_insert_prune_unit_tb.sv =====
// Testbench for the voxel hash map: directed and random transactions checked against a map model.
`timescale 1ns / 1ps
module voxel_hash_map_insert_prune_unit_tb;
  import vhm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TOTAL_ITEMS    = 1250;

  typedef struct {
    op_e                   op;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [SEL_SLOT_W-1:0] slot;
    logic [SEL_PT_W-1:0]   pt;
  } map_cmd_t;

  typedef struct {
    status_e            status;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    key_t               kx;
    key_t               ky;
    key_t               kz;
    logic [COUNT_W-1:0] removed;
  } map_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  vhm_in_if vin ();
  vhm_out_if vout ();

  voxel_hash_map_insert_prune_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (vin),
    .out_o      (vout),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // map model state
  logic [EDGE_W-1:0]   edge_q   = EDGE_RST;
  logic [CAP_W-1:0]    cap_q    = CAP_RST;
  logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
  logic   slot_used[TABLE_SLOTS];
  key_t   slot_kx[TABLE_SLOTS];
  key_t   slot_ky[TABLE_SLOTS];
  key_t   slot_kz[TABLE_SLOTS];
  int     slot_cnt[TABLE_SLOTS];
  coord_t pt_x[PS_DEPTH];
  coord_t pt_y[PS_DEPTH];
  coord_t pt_z[PS_DEPTH];

  map_cmd_t pending_cmds[$];
  map_rsp_t expected_results[$];
  int  sent_cnt = 0;
  int  recv_cnt = 0;
  int  err_cnt = 0;
  int  status_seen[8];
  int  idle_cycles = 0;
  bit  cmd_taken = 0;
  coord_t cx[6], cy[6], cz[6];

  function automatic key_t cell_of(coord_t p);
    longint d, v, m, q;
    d = (edge_q == 0) ? 1 : longint'(edge_q);
    v = longint'(p);
    m = (v < 0) ? -v : v;
    q = m / d;
    if (v < 0) q = -q;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return key_t'(q);
  endfunction

  function automatic logic [67:0] dist_sq(coord_t a, coord_t b);
    longint d;
    logic [67:0] m;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    m = 68'(d);
    return m * m;
  endfunction

  function automatic map_rsp_t predict_map_step(map_cmd_t c);
    map_rsp_t r;
    key_t kx, ky, kz;
    int found, free_slot, cap, f, base, removed;
    logic [67:0] acc, r2;
    r = '{status: ST_READ_EMPTY, x: 0, y: 0, z: 0, kx: 0, ky: 0, kz: 0, removed: 0};
    case (c.op)
      OP_ADD: begin
        kx = cell_of(c.x);
        ky = cell_of(c.y);
        kz = cell_of(c.z);
        r.kx = kx;
        r.ky = ky;
        r.kz = kz;
        cap = (cap_q > MAX_POINTS) ? MAX_POINTS : int'(cap_q);
        found = -1;
        free_slot = -1;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
          if (slot_used[s]) begin
            if (found < 0 && slot_kx[s] == kx && slot_ky[s] == ky && slot_kz[s] == kz)
              found = s;
          end else if (free_slot < 0) begin
            free_slot = s;
          end
        end
        if (found >= 0) begin
          f = slot_cnt[found];
          if (f < cap) begin
            base = found * MAX_POINTS + f;
            pt_x[base] = c.x;
            pt_y[base] = c.y;
            pt_z[base] = c.z;
            slot_cnt[found] = f + 1;
            r.status = ST_ADD_OLD;
          end else begin
            r.status = ST_VOX_FULL;
          end
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_kx[free_slot] = kx;
          slot_ky[free_slot] = ky;
          slot_kz[free_slot] = kz;
          base = free_slot * MAX_POINTS;
          pt_x[base] = c.x;
          pt_y[base] = c.y;
          pt_z[base] = c.z;
          slot_cnt[free_slot] = 1;
          r.status = ST_ADD_NEW;
        end else begin
          r.status = ST_TABLE_FULL;
        end
      end
      OP_PRUNE: begin
        r2 = 68'(radius_q) * 68'(radius_q);
        removed = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
          if (slot_used[s]) begin
            base = s * MAX_POINTS;
            acc = dist_sq(pt_x[base], c.x) + dist_sq(pt_y[base], c.y)
                + dist_sq(pt_z[base], c.z);
            if (acc > r2) begin
              slot_used[s] = 1'b0;
              removed++;
            end
          end
        end
        r.status = ST_PRUNED;
        r.removed = COUNT_W'(removed);
      end
      OP_READ: begin
        if (slot_used[c.slot] && int'(c.pt) < slot_cnt[c.slot] && c.pt < MAX_POINTS) begin
          base = int'(c.slot) * MAX_POINTS + int'(c.pt);
          r.x = pt_x[base];
          r.y = pt_y[base];
          r.z = pt_z[base];
          r.kx = slot_kx[c.slot];
          r.ky = slot_ky[c.slot];
          r.kz = slot_kz[c.slot];
          r.status = ST_READ_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    err_cnt++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d", recv_cnt, field, got, want);
  endtask

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    int mode, pct;
    if (!rst_ni) begin
      vin.valid <= 1'b0;
      vin.op <= '0;
      vin.pos_x <= '0;
      vin.pos_y <= '0;
      vin.pos_z <= '0;
      vin.slot_sel <= '0;
      vin.point_sel <= '0;
      vout.ready <= 1'b0;
    end else begin
      mode = sent_cnt * 3 / TOTAL_ITEMS;
      pct = (mode == 0) ? 23 : (mode == 1) ? 46 : 0;
      if (!vin.valid || cmd_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= pct) begin
          map_cmd_t c;
          c = pending_cmds.pop_front();
          vin.valid <= 1'b1;
          vin.op <= c.op;
          vin.pos_x <= c.x;
          vin.pos_y <= c.y;
          vin.pos_z <= c.z;
          vin.slot_sel <= c.slot;
          vin.point_sel <= c.pt;
        end else begin
          vin.valid <= 1'b0;
        end
      end
      pct = (mode == 0) ? 46 : (mode == 1) ? 23 : 0;
      vout.ready <= ($urandom_range(99) >= pct);
      cmd_taken = 0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    map_cmd_t c;
    map_rsp_t e;
    bit any;
    if (rst_ni) begin
      any = 0;
      if (vin.valid && vin.ready) begin
        c.op = op_e'(vin.op);
        c.x = vin.pos_x;
        c.y = vin.pos_y;
        c.z = vin.pos_z;
        c.slot = vin.slot_sel;
        c.pt = vin.point_sel;
        e = predict_map_step(c);
        expected_results = {expected_results, e};
        sent_cnt++;
        cmd_taken = 1;
        any = 1;
      end
      if (vout.valid && vout.ready) begin
        any = 1;
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("result %0d arrived with nothing expected", recv_cnt);
        end else begin
          e = expected_results.pop_front();
          status_seen[vout.status]++;
          if (vout.status != e.status) report_mismatch("status", vout.status, e.status);
          if (vout.out_x != e.x) report_mismatch("out_x", vout.out_x, e.x);
          if (vout.out_y != e.y) report_mismatch("out_y", vout.out_y, e.y);
          if (vout.out_z != e.z) report_mismatch("out_z", vout.out_z, e.z);
          if (vout.cell_x != e.kx) report_mismatch("cell_x", vout.cell_x, e.kx);
          if (vout.cell_y != e.ky) report_mismatch("cell_y", vout.cell_y, e.ky);
          if (vout.cell_z != e.kz) report_mismatch("cell_z", vout.cell_z, e.kz);
          if (vout.removed_count != e.removed)
            report_mismatch("removed_count", vout.removed_count, e.removed);
        end
        recv_cnt++;
      end
      idle_cycles = any ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_cmd(op_e op, coord_t x, coord_t y, coord_t z, int slot, int pt);
    map_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.z = z;
    c.slot = SEL_SLOT_W'(slot);
    c.pt = SEL_PT_W'(pt);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || vin.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_VOXEL_EDGE:  edge_q = EDGE_W'(val);
      CFG_POINTS_PER:  cap_q = CAP_W'(val);
      CFG_KEEP_RADIUS: radius_q = RADIUS_W'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic coord_t near(coord_t c);
    int span;
    span = (edge_q == 0) ? 8 : int'(edge_q) * 3;
    return c + coord_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic push_random(int n);
    int k, sel, w;
    for (int i = 0; i < 6; i++) begin
      cx[i] = coord_t'($urandom) >>> $urandom_range(4, 12);
      cy[i] = coord_t'($urandom) >>> $urandom_range(4, 12);
      cz[i] = coord_t'($urandom) >>> $urandom_range(4, 12);
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      k = $urandom_range(5);
      if (sel < 55) begin
        push_cmd(OP_ADD, near(cx[k]), near(cy[k]), near(cz[k]), $urandom, $urandom);
      end else if (sel < 63) begin
        push_cmd(OP_ADD, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 88) begin
        push_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(15),
                 $urandom_range(cap_q));
      end else if (sel < 93) begin
        push_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(1023),
                 $urandom_range(31));
      end else if (sel < 96) begin
        push_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        w = $urandom_range(1);
        push_cmd(OP_PRUNE, w ? near(cx[k]) : coord_t'($urandom), near(cy[k]), near(cz[k]),
                 $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_cnt[s] = 0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration
    push_cmd(OP_ADD, 0, 0, 0, 0, 0);
    push_cmd(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    push_cmd(OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    push_cmd(OP_ADD, 65535, -65535, 1, 0, 0);
    push_cmd(OP_ADD, -65536, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 0, 1);
    push_cmd(OP_READ, 0, 0, 0, 0, 2);
    push_cmd(OP_READ, 0, 0, 0, 1023, 0);
    push_cmd(OP_READ, 0, 0, 0, 0, 31);
    push_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_cmd(OP_PRUNE, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 1, 0);
    push_cmd(OP_ADD, 100 << 16, 100 << 16, 100 << 16, 0, 0);
    drain();

    // fine grid, one point per voxel: fill the table, then prune everything
    write_cfg(CFG_VOXEL_EDGE, 655);
    write_cfg(CFG_POINTS_PER, 1);
    write_cfg(CFG_KEEP_RADIUS, 32'h7fffffff);
    for (int i = 0; i < 1030; i++)
      push_cmd(OP_ADD, i * 1000, -i * 700, i * 3, 0, 0);
    push_cmd(OP_ADD, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 1023, 0);
    push_cmd(OP_PRUNE, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    drain();
    write_cfg(CFG_KEEP_RADIUS, 0);
    push_cmd(OP_PRUNE, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    drain();

    write_cfg(CFG_VOXEL_EDGE, 655360);
    write_cfg(CFG_POINTS_PER, 31);
    write_cfg(CFG_KEEP_RADIUS, RADIUS_RST);
    push_random(80);
    drain();

    // zero edge and zero cap
    write_cfg(CFG_VOXEL_EDGE, 0);
    write_cfg(CFG_POINTS_PER, 0);
    push_cmd(OP_ADD, 5, 5, 5, 0, 0);
    push_cmd(OP_ADD, 5, 5, 5, 0, 0);
    push_cmd(OP_ADD, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      write_cfg(CFG_VOXEL_EDGE, $urandom_range(655, 655360));
      write_cfg(CFG_POINTS_PER, $urandom_range(1, 20));
      write_cfg(CFG_KEEP_RADIUS, $urandom_range(1 << 20, 32'h7fffffff));
      push_random(60);
      drain();
    end

    repeat (200) @(negedge clk_i);
    $display("ran %0d commands, %0d results: %0d new, %0d existing, %0d voxel full,",
             sent_cnt, recv_cnt, status_seen[ST_ADD_NEW], status_seen[ST_ADD_OLD],
             status_seen[ST_VOX_FULL]);
    $display("%0d table full, %0d prunes, %0d reads hit, %0d reads empty; %0d errors",
             status_seen[ST_TABLE_FULL], status_seen[ST_PRUNED], status_seen[ST_READ_OK],
             status_seen[ST_READ_EMPTY], err_cnt);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vhm_pkg.sv
rtl/vhm_if.sv
rtl/vhm_front.sv
rtl/vhm_queue.sv
rtl/vhm_back.sv
rtl/voxel_hash_map_insert_prune_unit.sv
verif/voxel_hash_map_insert_prune_unit_tb.sv
